@@ hdl/indexed_insert_delete_array_macros.svh @@
// Assertion helpers used by iida_ctrl.
`ifndef INDEXED_INSERT_DELETE_ARRAY_MACROS_SVH
`define INDEXED_INSERT_DELETE_ARRAY_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IIDA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IIDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/iida_pkg.sv @@
`timescale 1ns / 1ps

package iida_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int WORD_W    = 32;
    localparam int OP_W      = 3;
    localparam int ST_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_SET    = 3'd3,
        OP_GET    = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN
    } cell_op_t;

    // Broadcast to every cell of the row.
    typedef struct packed {
        cell_op_t          op;
        logic [WORD_W-1:0] word;
    } cell_cmd_t;

endpackage

@@ hdl/iida_cell.sv @@
`timescale 1ns / 1ps

module iida_cell
    import iida_pkg::*;
#(
    parameter int IDX_W = 7,
    parameter int INDEX = 0
)
(
    input  logic              clk,
    input  cell_cmd_t         cmd,
    input  logic [IDX_W-1:0]  pos,
    input  logic [WORD_W-1:0] from_below,
    input  logic [WORD_W-1:0] from_above,
    output logic [WORD_W-1:0] word,
    output logic [WORD_W-1:0] sel_word
);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic              at_pos;
    logic              above_pos;

    assign at_pos    = (pos == IDX_W'(INDEX));
    assign above_pos = (IDX_W'(INDEX) > pos);

    always_comb
    begin
        word_next = word_reg;
        unique case (cmd.op)
            CELL_HOLD:
            begin
                word_next = word_reg;
            end
            CELL_WRITE:
            begin
                if (at_pos)
                begin
                    word_next = cmd.word;
                end
            end
            CELL_SHIFT_UP:
            begin
                if (at_pos)
                begin
                    word_next = cmd.word;
                end
                else if (above_pos)
                begin
                    word_next = from_below;
                end
            end
            CELL_SHIFT_DOWN:
            begin
                if (at_pos || above_pos)
                begin
                    word_next = from_above;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    // Payload only, no reset.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word     = word_reg;
    assign sel_word = at_pos ? word_reg : '0;

endmodule

@@ hdl/iida_ctrl.sv @@
`timescale 1ns / 1ps

`include "indexed_insert_delete_array_macros.svh"

module iida_ctrl
    import iida_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [OP_W-1:0]   opcode,
    input  logic [IDX_W-1:0]  position,
    input  logic [WORD_W-1:0] word_in,
    output cell_cmd_t         cmd,
    output logic [IDX_W-1:0]  cell_pos,
    output status_t           status,
    output logic [IDX_W-1:0]  count_after,
    output logic              get_ok
);

    localparam logic [IDX_W-1:0] FULL_COUNT = IDX_W'(DEPTH);
    localparam logic [IDX_W-1:0] COUNT_ONE  = IDX_W'(1);

    logic [IDX_W-1:0] count_reg;
    logic [IDX_W-1:0] count_next;
    logic             full;
    logic             in_range;
    cell_op_t         cell_op;

    assign full     = (count_reg == FULL_COUNT);
    assign in_range = (position < count_reg);

    always_comb
    begin
        cell_op    = CELL_HOLD;
        cell_pos   = position;
        status     = ST_DONE;
        count_next = count_reg;
        get_ok     = 1'b0;
        unique case (opcode)
            OP_PUSH:
            begin
                cell_pos = count_reg;
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cell_op    = CELL_WRITE;
                    count_next = count_reg + COUNT_ONE;
                end
            end
            OP_INSERT:
            begin
                // range check wins over full
                if (position > count_reg)
                begin
                    status = ST_RANGE;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    cell_op    = CELL_SHIFT_UP;
                    count_next = count_reg + COUNT_ONE;
                end
            end
            OP_DELETE:
            begin
                if (!in_range)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    cell_op    = CELL_SHIFT_DOWN;
                    count_next = count_reg - COUNT_ONE;
                end
            end
            OP_SET:
            begin
                if (!in_range)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    cell_op = CELL_WRITE;
                end
            end
            OP_GET:
            begin
                if (!in_range)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    get_ok = 1'b1;
                end
            end
            default:
            begin
                cell_op = CELL_HOLD;
            end
        endcase
    end

    assign cmd.op      = accept ? cell_op : CELL_HOLD;
    assign cmd.word    = word_in;
    assign count_after = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    `IIDA_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_COUNT,
        "fill count past depth")
    `IIDA_ASSERT_NEXT(a_grow, clk, rst_n,
        accept && (cell_op == CELL_SHIFT_UP || (opcode == OP_PUSH && !full)),
        count_reg == $past(count_reg) + COUNT_ONE, "count did not grow")
    `IIDA_ASSERT_NEXT(a_shrink, clk, rst_n, accept && cell_op == CELL_SHIFT_DOWN,
        count_reg == $past(count_reg) - COUNT_ONE, "count did not shrink")
    `IIDA_ASSERT_NEXT(a_reject_hold, clk, rst_n, accept && status != ST_DONE,
        $stable(count_reg), "rejected transaction changed count")

endmodule

@@ hdl/iida_obuf.sv @@
`timescale 1ns / 1ps

module iida_obuf
#(
    parameter int W = 41
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    output logic         up_stall,
    input  logic [W-1:0] up_data,
    output logic         dn_valid,
    input  logic         dn_stall,
    output logic [W-1:0] dn_data
);

    logic         out_valid_reg;
    logic         out_valid_next;
    logic [W-1:0] out_data_reg;
    logic [W-1:0] out_data_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    logic [W-1:0] skid_data_reg;
    logic [W-1:0] skid_data_next;
    logic         push;
    logic         out_free;

    assign push     = up_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !dn_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            out_valid_next  = skid_valid_reg || push;
            out_data_next   = skid_valid_reg ? skid_data_reg : up_data;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = up_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign up_stall = skid_valid_reg;
    assign dn_valid = out_valid_reg;
    assign dn_data  = out_data_reg;

endmodule

@@ hdl/indexed_insert_delete_array.sv @@
// An accepted transaction's result is registered in the output buffer.
// Throughput: one transaction per cycle while in_stall is low; the whole row of cells shifts at once.
// A two-entry output buffer keeps input open while one result waits downstream.
// Reset (rst_n, async, active low) clears the fill count and the buffer valid flags;
// entry words are not reset and are only read below the fill count.
`timescale 1ns / 1ps

module indexed_insert_delete_array
    import iida_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OP_W-1:0]          opcode,
    input  logic [IDX_W-1:0]         position,
    input  logic signed [WORD_W-1:0] word_in,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [WORD_W-1:0] read_word,
    output logic [IDX_W-1:0]         element_count,
    output logic [ST_W-1:0]          status
);

    localparam int RES_W = WORD_W + IDX_W + ST_W;

    logic              accept;
    cell_cmd_t         cmd;
    logic [IDX_W-1:0]  cell_pos;
    status_t           op_status;
    logic [IDX_W-1:0]  count_after;
    logic              get_ok;

    // Neighbor taps of the cell row; word_row[i] is cell i's stored word.
    logic [WORD_W-1:0] word_row [DEPTH];
    logic [WORD_W-1:0] sel_row  [DEPTH];
    logic [WORD_W-1:0] read_any;
    logic [WORD_W-1:0] read_val;
    logic [RES_W-1:0]  res_bits;
    logic [RES_W-1:0]  out_bits;

    // A transaction is taken when the output buffer has room for its result.
    assign accept = in_valid && !in_stall;

    iida_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .opcode      (opcode),
        .position    (position),
        .word_in     (word_in),
        .cmd         (cmd),
        .cell_pos    (cell_pos),
        .status      (op_status),
        .count_after (count_after),
        .get_ok      (get_ok)
    );

    // Row of cells: insert moves each word up from its lower neighbor, delete
    // pulls each word down from its upper neighbor. The row ends are tied off;
    // their values only ever land in slots at or past the fill count.
    for (genvar gi = 0; gi < DEPTH; gi++)
    begin : g_cell
        logic [WORD_W-1:0] below;
        logic [WORD_W-1:0] above;

        if (gi == 0)
        begin : g_bot
            assign below = '0;
        end
        else
        begin : g_mid_lo
            assign below = word_row[gi-1];
        end

        if (gi == DEPTH - 1)
        begin : g_top
            assign above = '0;
        end
        else
        begin : g_mid_hi
            assign above = word_row[gi+1];
        end

        iida_cell #(
            .IDX_W (IDX_W),
            .INDEX (gi)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .pos        (cell_pos),
            .from_below (below),
            .from_above (above),
            .word       (word_row[gi]),
            .sel_word   (sel_row[gi])
        );
    end

    // Each cell drives its word only when it matches the position, so the get
    // path is a plain OR across the row.
    always_comb
    begin
        read_any = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            read_any = read_any | sel_row[i];
        end
    end

    assign read_val = get_ok ? read_any : '0;
    assign res_bits = {read_val, count_after, op_status};

    iida_obuf #(
        .W (RES_W)
    ) u_obuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_stall (in_stall),
        .up_data  (res_bits),
        .dn_valid (out_valid),
        .dn_stall (out_stall),
        .dn_data  (out_bits)
    );

    assign read_word     = $signed(out_bits[RES_W-1 -: WORD_W]);
    assign element_count = out_bits[ST_W +: IDX_W];
    assign status        = out_bits[ST_W-1:0];

endmodule
